>>> sv/srlm_pkg.sv
// Shared types and constants for the stereo RMS level meter.
package srlm_pkg;

  // Defaults for the configuration registers after reset.
  localparam logic [15:0] KEEP_RESET       = 16'd60948;
  localparam logic [15:0] FULL_SCALE_RESET = 16'd11141;

  // Frame count at which accumulation stops.
  localparam int MAX_FRAMES_DEF = 1024;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_KEEP   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE_LEVEL = CFG_INDEX_W'(1);

  // Datapath widths fixed by the arithmetic.
  localparam int SUM_W  = 40;  // saturating sum of squares
  localparam int PROD_W = 34;  // shared 17 x 17 multiplier
  localparam int REM_W  = 20;  // partial remainder of the shared subtract unit
  localparam int SRC_W  = 32;  // bits still to be shifted into the remainder
  localparam int RES_W  = 31;  // quotient or root being built
  localparam int STEP_W = 5;

  // Iteration counts, minus one, for the three serial operations.
  localparam logic [STEP_W-1:0] RMS_DIV_LAST  = STEP_W'(30);
  localparam logic [STEP_W-1:0] SQRT_LAST     = STEP_W'(15);
  localparam logic [STEP_W-1:0] VOL_DIV_LAST  = STEP_W'(15);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_LEFT,
    ST_SQ_RIGHT,
    ST_SQ_ADD,
    ST_RMS_START,
    ST_DIV_RMS,
    ST_SQRT,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_MUL_SUM,
    ST_VOL_START,
    ST_DIV_VOL,
    ST_EMIT
  } state_t;

endpackage

>>> sv/stereo_rms_level_meter_core.sv
// Stereo RMS level meter: accumulation, serial divide and root, smoothing, scaling.
//
// Input channel (in_valid / in_stall) carries one stereo frame per item:
// left_sample, right_sample (Q1.15) and end_of_buffer. Each sample is halved,
// squared and added into a saturating 40 bit sum; frames are counted up to
// MAX_FRAMES, after which further frames only have their end mark obeyed.
// The two squares of a frame are formed one after the other, since both
// go through one shared multiplier, and no new frame is taken meanwhile.
// On a frame marked end_of_buffer the block works out the RMS, the smoothed
// level and the scaled volume with one shared subtract unit and the same
// multiplier: 31 divide steps, 16 root steps, the multiplies of the old level
// and the new root by their weights, their sum, and up to 16 more divide steps,
// none when the volume clamps; the squaring is skipped once the count is full.
// in_stall stays high from acceptance until the result is loaded for output.
// The output channel (out_valid / out_stall) has its own result register, so a
// stalled result does not block new frames; a following end frame waits in
// its last step until the earlier result is taken.
// Reset (rst, synchronous) clears the sum, the count and the level, loads the
// register defaults and drops out_valid. Configuration is to be written through
// cfg_write / cfg_index / cfg_data while the block is idle; the block does not enforce this.
module stereo_rms_level_meter_core #(
  parameter int MAX_FRAMES = srlm_pkg::MAX_FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [srlm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [srlm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 left_sample,
  input  logic signed [15:0]                 right_sample,
  input  logic                               end_of_buffer,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [15:0]                        smoothed_level,
  output logic [15:0]                        scaled_volume
);
  import srlm_pkg::*;

  localparam int FC_W = $clog2(MAX_FRAMES + 1);

  state_t state, state_next;

  logic [15:0]        keep;
  logic [15:0]        full_scale;
  logic [SUM_W-1:0]   square_sum;
  logic [FC_W-1:0]    frame_count;
  logic [15:0]        level;

  logic [14:0]        left_mag, right_mag;
  logic               eob;
  logic [PROD_W-1:0]  prod_q;
  logic [31:0]        acc;
  logic [REM_W-1:0]   rem;
  logic [SRC_W-1:0]   src;
  logic [RES_W-1:0]   res;
  logic [STEP_W-1:0]  step;
  logic [15:0]        volume;

  logic               in_accept, out_take, load_out, count_open;
  logic signed [15:0] half_left, half_right, mag_left, mag_right;
  logic [16:0]        mul_a, mul_b;
  logic [PROD_W-1:0]  product;
  logic [SUM_W:0]     sum_add;
  logic [32:0]        level_sum;
  logic [21:0]        shifted, operand;
  logic [22:0]        diff;
  logic               fits;

  assign in_accept  = in_valid && !in_stall;
  assign out_take   = out_valid && !out_stall;
  assign count_open = frame_count < FC_W'(MAX_FRAMES);

  // Halve with an arithmetic shift; the magnitude of a halved sample fits 15 bits.
  assign half_left  = left_sample >>> 1;
  assign half_right = right_sample >>> 1;
  assign mag_left   = half_left[15] ? -half_left : half_left;
  assign mag_right  = half_right[15] ? -half_right : half_right;

  // Shared multiplier.
  always_comb begin
    unique case (state)
      ST_SQ_LEFT: begin
        mul_a = {2'b00, left_mag};
        mul_b = {2'b00, left_mag};
      end
      ST_SQ_RIGHT: begin
        mul_a = {2'b00, right_mag};
        mul_b = {2'b00, right_mag};
      end
      ST_MUL_OLD: begin
        mul_a = {1'b0, level};
        mul_b = {1'b0, keep};
      end
      ST_MUL_NEW: begin
        mul_a = {1'b0, res[15:0]};
        mul_b = 17'h10000 - {1'b0, keep};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign product   = mul_a * mul_b;
  assign sum_add   = {1'b0, square_sum} + {{(SUM_W + 1 - PROD_W){1'b0}}, prod_q};
  assign level_sum = {1'b0, acc} + {1'b0, prod_q[31:0]};

  // Shared trial subtract: one quotient bit or one root bit per cycle.
  always_comb begin
    if (state == ST_SQRT) begin
      shifted = {rem, src[SRC_W-1 -: 2]};
      operand = {4'b0000, res[15:0], 2'b01};
    end else begin
      shifted = {1'b0, rem, src[SRC_W-1]};
      if (state == ST_DIV_RMS) begin
        operand = 22'(frame_count);
      end else begin
        operand = {6'b000000, full_scale};
      end
    end
    diff = {1'b0, shifted} - {1'b0, operand};
    fits = !diff[22];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = rst || (state != ST_IDLE);
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (count_open) begin
            state_next = ST_SQ_LEFT;
          end else if (end_of_buffer) begin
            state_next = ST_RMS_START;
          end
        end
      end
      ST_SQ_LEFT:   state_next = ST_SQ_RIGHT;
      ST_SQ_RIGHT:  state_next = ST_SQ_ADD;
      ST_SQ_ADD:    state_next = eob ? ST_RMS_START : ST_IDLE;
      ST_RMS_START: state_next = ST_DIV_RMS;
      ST_DIV_RMS: begin
        if (step == '0) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (step == '0) begin
          state_next = ST_MUL_OLD;
        end
      end
      ST_MUL_OLD:   state_next = ST_MUL_NEW;
      ST_MUL_NEW:   state_next = ST_MUL_SUM;
      ST_MUL_SUM:   state_next = ST_VOL_START;
      ST_VOL_START: state_next = (level >= full_scale) ? ST_EMIT : ST_DIV_VOL;
      ST_DIV_VOL: begin
        if (step == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep        <= KEEP_RESET;
      full_scale  <= FULL_SCALE_RESET;
      square_sum  <= '0;
      frame_count <= '0;
      level       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SMOOTHING_KEEP:   keep <= cfg_data;
          REG_FULL_SCALE_LEVEL: full_scale <= cfg_data;
          default: ;
        endcase
      end
      // The square sum saturates; adding both squares one after the other
      // saturates exactly when their total would.
      if (state == ST_SQ_RIGHT || state == ST_SQ_ADD) begin
        square_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
      if (state == ST_SQ_ADD) begin
        frame_count <= frame_count + FC_W'(1);
      end
      if (state == ST_MUL_SUM) begin
        level <= level_sum[31:16];
      end
      if (load_out) begin
        square_sum  <= '0;
        frame_count <= '0;
        out_valid   <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the serial datapath.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      left_mag  <= mag_left[14:0];
      right_mag <= mag_right[14:0];
      eob       <= end_of_buffer;
    end
    unique case (state)
      ST_SQ_LEFT, ST_SQ_RIGHT, ST_MUL_OLD, ST_MUL_NEW: begin
        prod_q <= product;
        if (state == ST_MUL_NEW) begin
          acc <= prod_q[31:0];
        end
      end
      ST_RMS_START: begin
        // The quotient of 2*sum by the count stays below 2^31, so the top ten
        // dividend bits already sit below the divisor.
        rem  <= REM_W'(square_sum[SUM_W-1 -: 10]);
        src  <= {square_sum[29:0], 2'b00};
        res  <= '0;
        step <= RMS_DIV_LAST;
      end
      ST_DIV_RMS: begin
        if (step == '0) begin
          // An empty count gives a root of zero.
          src  <= (frame_count == '0) ? '0 : {1'b0, res[RES_W-2:0], fits};
          rem  <= '0;
          res  <= '0;
          step <= SQRT_LAST;
        end else begin
          rem  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
          src  <= {src[SRC_W-2:0], 1'b0};
          res  <= {res[RES_W-2:0], fits};
          step <= step - STEP_W'(1);
        end
      end
      ST_SQRT: begin
        rem  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        src  <= {src[SRC_W-3:0], 2'b00};
        res  <= {res[RES_W-2:0], fits};
        step <= step - STEP_W'(1);
      end
      ST_VOL_START: begin
        // A level at or above full scale clamps; this also covers a zero full scale.
        volume <= 16'hFFFF;
        rem    <= REM_W'(level);
        src    <= '0;
        res    <= '0;
        step   <= VOL_DIV_LAST;
      end
      ST_DIV_VOL: begin
        rem  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        res  <= {res[RES_W-2:0], fits};
        step <= step - STEP_W'(1);
        if (step == '0) begin
          volume <= {res[14:0], fits};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      smoothed_level <= level;
      scaled_volume  <= volume;
    end
  end

endmodule

>>> sv/srlm_checker.sv
// Port-level checks for the stereo RMS level meter, bound to the top level.
module srlm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        end_of_buffer,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] smoothed_level,
  input logic [15:0] scaled_volume
);

  // A result held by the receiver keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(smoothed_level) && $stable(scaled_volume))
    else $error("stalled result changed");

  // An end frame always starts the level computation.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_buffer |=> in_stall)
    else $error("end frame did not start the level computation");

  // The smoothed level never exceeds one half of full range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> smoothed_level <= 16'd32768)
    else $error("smoothed level out of range");

  // A new result appears as the block goes back to taking frames.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while the block stayed busy");

  // The block is ready right after reset.
  assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_stall)
    else $error("block busy after reset");

endmodule

bind stereo_rms_level_meter_core srlm_checker u_srlm_checker (.*);
